// ===== src/dpf_pkg.sv =====
// dpf_pkg: shared types and constants of the descriptor pool and queue
// payload structs, command and status codes, controller/datapath links
// no dependencies
`default_nettype none

package dpf_pkg;

    localparam int KIND_W = 3;
    localparam int IDX_W  = 7;
    localparam int HDL_W  = 32;
    localparam int PORT_W = 4;
    localparam int STS_W  = 3;
    localparam int CNT_W  = 7;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_QUEUE_LIMIT = 1'b0;   // register index, paddr[2]
    localparam logic [CNT_W-1:0] QUEUE_LIMIT_RST = 7'd64;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ATTACH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENQ     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEQ     = 3'd4;

    // result status
    localparam logic [STS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STS_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  desc_index;
        logic [HDL_W-1:0]  buffer_handle;
        logic [PORT_W-1:0] port_tag;
    } t_item;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [IDX_W-1:0]  result_desc;
        logic [HDL_W-1:0]  released_handle;
        logic              front_valid;
        logic [IDX_W-1:0]  front_desc;
        logic [HDL_W-1:0]  front_handle;
        logic [PORT_W-1:0] front_port;
        logic [CNT_W-1:0]  queue_count;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic clear;      // clearing pass write
        logic load;       // capture a new command
        logic fetch;      // dequeue: take ring entry, read its descriptor
        logic commit;     // memory writes and state update
        logic front_hdl;  // take front index, read its descriptor
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic clear_last; // last entry of the clearing pass
        logic deq_go;     // latched command is a dequeue on a non-empty queue
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/dpf_ctrl.sv =====
// dpf_ctrl: command sequencer of the descriptor pool and queue
// drives the datapath through dpf_pkg::t_dp_ctl, watches dpf_pkg::t_dp_sts
// depends on dpf_pkg
`default_nettype none

module dpf_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  dpf_pkg::t_dp_sts  i_sts,
    output dpf_pkg::t_dp_ctl  o_ctl,
    output logic              o_busy,
    output logic              o_result_valid
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_FETCH  = 8'b0000_1000,
        S_COMMIT = 8'b0001_0000,
        S_FRONT  = 8'b0010_0000,
        S_FHDL   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_busy         = !((r_state == S_IDLE) || (r_state == S_DONE));
    assign o_result_valid = (r_state == S_DONE);
    assign w_accept       = i_start && !o_busy;

    assign o_ctl.clear     = (r_state == S_CLEAR);
    assign o_ctl.load      = w_accept;
    assign o_ctl.fetch     = (r_state == S_FETCH);
    assign o_ctl.commit    = (r_state == S_COMMIT);
    assign o_ctl.front_hdl = (r_state == S_FHDL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_DONE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.deq_go) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_FETCH:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_FRONT;
            S_FRONT:  n_state = S_FHDL;
            S_FHDL:   n_state = S_DONE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/dpf_datapath.sv =====
// dpf_datapath: descriptor memories, index ring, free-list head and queue pointers
// steered step by step by dpf_ctrl
// depends on dpf_pkg
`default_nettype none

module dpf_datapath #(
    parameter int POOL_DEPTH = 64,
    parameter int RING_DEPTH = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dpf_pkg::t_dp_ctl                  i_ctl,
    input  dpf_pkg::t_item                    i_item,
    input  wire [dpf_pkg::CNT_W-1:0]          i_queue_limit,
    output dpf_pkg::t_dp_sts                  o_sts,
    output dpf_pkg::t_result                  o_result
);

    localparam int PA_W = $clog2(POOL_DEPTH + 1);
    localparam int RP_W = $clog2(RING_DEPTH);
    localparam int IW   = dpf_pkg::IDX_W;
    localparam int HW   = dpf_pkg::HDL_W;
    localparam int PW   = dpf_pkg::PORT_W;
    localparam int CW   = dpf_pkg::CNT_W;
    localparam int SW   = dpf_pkg::STS_W;

    // memories, entry 0 of the pool arrays is never used
    logic [PA_W-1:0] m_links   [POOL_DEPTH+1];
    logic [HW-1:0]   m_handles [POOL_DEPTH+1];
    logic [PW-1:0]   m_ports   [POOL_DEPTH+1];
    logic [IW-1:0]   m_ring    [RING_DEPTH];

    // registered read data
    logic [PA_W-1:0] r_link_q;
    logic [HW-1:0]   r_hdl_q;
    logic [PW-1:0]   r_port_q;
    logic [IW-1:0]   r_ring_q;

    // command and bookkeeping
    dpf_pkg::t_item  r_cmd;
    logic [PA_W-1:0] r_head, n_head;
    logic [RP_W-1:0] r_rp, n_rp;
    logic [RP_W-1:0] r_wp, n_wp;
    logic [CW-1:0]   r_count, n_count;
    logic [PA_W-1:0] r_clr_addr;
    logic [IW-1:0]   r_d;
    logic [IW-1:0]   r_front_desc;
    logic [SW-1:0]   r_status, n_status;
    logic [IW-1:0]   r_rdesc, n_rdesc;
    logic [HW-1:0]   r_rel, n_rel;

    // write ports
    logic            w_l_we, w_h_we, w_p_we, w_r_we;
    logic [PA_W-1:0] w_l_wa, w_h_wa, w_p_wa;
    logic [PA_W-1:0] w_l_wd;
    logic [HW-1:0]   w_h_wd;
    logic [PW-1:0]   w_p_wd;

    logic [PA_W-1:0] w_hp_ra;
    logic [PA_W-1:0] w_idx_a;
    logic [PA_W-1:0] w_d_a;
    logic            w_idx_ok;
    logic            w_d_ok;
    logic            w_full;
    logic            w_nonempty;

    assign w_idx_a    = PA_W'(r_cmd.desc_index);
    assign w_d_a      = PA_W'(r_d);
    assign w_idx_ok   = (r_cmd.desc_index != '0) &&
                        (32'(r_cmd.desc_index) <= 32'(POOL_DEPTH));
    assign w_d_ok     = (r_d != '0) && (32'(r_d) <= 32'(POOL_DEPTH));
    assign w_full     = (r_count >= i_queue_limit) || (32'(r_count) >= 32'(RING_DEPTH));
    assign w_nonempty = (r_count != '0);

    // both the dequeue fetch and the front lookup address by the ring word
    assign w_hp_ra = (i_ctl.fetch || i_ctl.front_hdl) ? PA_W'(r_ring_q) : w_idx_a;

    assign o_sts.clear_last = (r_clr_addr == PA_W'(POOL_DEPTH));
    assign o_sts.deq_go     = (r_cmd.kind == dpf_pkg::KIND_DEQ) && w_nonempty;

    always_comb begin
        n_head   = r_head;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_count  = r_count;
        n_status = dpf_pkg::ST_OK;
        n_rdesc  = '0;
        n_rel    = '0;
        w_l_we   = 1'b0;
        w_l_wa   = r_clr_addr;
        w_l_wd   = '0;
        w_h_we   = 1'b0;
        w_h_wa   = r_clr_addr;
        w_h_wd   = '0;
        w_p_we   = 1'b0;
        w_p_wa   = r_clr_addr;
        w_p_wd   = '0;
        w_r_we   = 1'b0;
        if (i_ctl.clear) begin
            w_l_we = 1'b1;
            w_h_we = 1'b1;
            w_p_we = 1'b1;
            if (r_clr_addr != PA_W'(POOL_DEPTH)) begin
                w_l_wd = r_clr_addr + 1'b1;
            end
        end else if (i_ctl.commit) begin
            unique case (r_cmd.kind)
                dpf_pkg::KIND_ALLOC: begin
                    if (r_head == '0) begin
                        n_status = dpf_pkg::ST_EXHAUSTED;
                    end else if (r_cmd.buffer_handle == '0) begin
                        n_status = dpf_pkg::ST_NULL;
                    end else begin
                        n_head  = r_link_q;
                        w_h_we  = 1'b1;
                        w_h_wa  = r_head;
                        w_h_wd  = r_cmd.buffer_handle;
                        w_p_we  = 1'b1;
                        w_p_wa  = r_head;
                        w_p_wd  = r_cmd.port_tag;
                        n_rdesc = IW'(r_head);
                    end
                end
                dpf_pkg::KIND_ATTACH: begin
                    if (!w_idx_ok || (r_cmd.buffer_handle == '0)) begin
                        n_status = dpf_pkg::ST_NULL;
                    end else begin
                        w_h_we = 1'b1;
                        w_h_wa = w_idx_a;
                        w_h_wd = r_cmd.buffer_handle;
                    end
                end
                dpf_pkg::KIND_RELEASE: begin
                    if (!w_idx_ok) begin
                        n_status = dpf_pkg::ST_NULL;
                    end else begin
                        n_rel  = r_hdl_q;
                        w_h_we = 1'b1;
                        w_h_wa = w_idx_a;
                        w_p_we = 1'b1;
                        w_p_wa = w_idx_a;
                        w_l_we = 1'b1;
                        w_l_wa = w_idx_a;
                        w_l_wd = r_head;
                        n_head = w_idx_a;
                    end
                end
                dpf_pkg::KIND_ENQ: begin
                    if (!w_idx_ok) begin
                        n_status = dpf_pkg::ST_NULL;
                    end else if (w_full) begin
                        n_status = dpf_pkg::ST_FULL;
                    end else begin
                        w_r_we  = 1'b1;
                        n_wp    = (r_wp == RP_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                dpf_pkg::KIND_DEQ: begin
                    if (!w_nonempty) begin
                        n_status = dpf_pkg::ST_EMPTY;
                    end else begin
                        if (w_d_ok) begin
                            n_rel  = r_hdl_q;
                            w_h_we = 1'b1;
                            w_h_wa = w_d_a;
                            w_p_we = 1'b1;
                            w_p_wa = w_d_a;
                            w_l_we = 1'b1;
                            w_l_wa = w_d_a;
                            w_l_wd = r_head;
                            n_head = w_d_a;
                        end
                        n_rdesc = r_d;
                        n_rp    = (r_rp == RP_W'(RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    // unused kinds change nothing
                end
            endcase
        end
    end

    // memories and read registers
    always_ff @(posedge i_clk) begin
        if (w_l_we) begin
            m_links[w_l_wa] <= w_l_wd;
        end
        if (w_h_we) begin
            m_handles[w_h_wa] <= w_h_wd;
        end
        if (w_p_we) begin
            m_ports[w_p_wa] <= w_p_wd;
        end
        if (w_r_we) begin
            m_ring[r_wp] <= r_cmd.desc_index;
        end
        r_link_q <= m_links[r_head];
        r_hdl_q  <= m_handles[w_hp_ra];
        r_port_q <= m_ports[w_hp_ra];
        r_ring_q <= m_ring[r_rp];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_item;
        end
        if (i_ctl.fetch) begin
            r_d <= r_ring_q;
        end
        if (i_ctl.front_hdl) begin
            r_front_desc <= r_ring_q;
        end
        if (i_ctl.commit) begin
            r_status <= n_status;
            r_rdesc  <= n_rdesc;
            r_rel    <= n_rel;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= PA_W'(1);
            r_rp       <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            r_head  <= n_head;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_count <= n_count;
            if (i_ctl.clear && !o_sts.clear_last) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_result.status          = r_status;
    assign o_result.result_desc     = r_rdesc;
    assign o_result.released_handle = r_rel;
    assign o_result.front_valid     = w_nonempty;
    assign o_result.front_desc      = w_nonempty ? r_front_desc : '0;
    assign o_result.front_handle    = w_nonempty ? r_hdl_q : '0;
    assign o_result.front_port      = w_nonempty ? r_port_q : '0;
    assign o_result.queue_count     = r_count;

endmodule

`default_nettype wire

// ===== src/descriptor_pool_fifo.sv =====
// descriptor_pool_fifo: top level of the descriptor pool and queue
// holds the configuration register, joins dpf_ctrl and dpf_datapath
// depends on dpf_pkg, dpf_ctrl, dpf_datapath
//
//  channel   | ports                                        | transfer when
//  ----------+----------------------------------------------+----------------------------
//  command   | i_start, o_busy, i_item                      | i_start high, o_busy low
//  result    | o_result_valid, o_result                     | every cycle o_result_valid
//  config    | psel, penable, pwrite, paddr, pwdata, prdata | psel, penable, pwrite high
//
// a result transfers in state done after read, commit, front and fhdl, with fetch after
// read for a non-empty dequeue; the sequencer reads and writes back the synchronous
// descriptor memories, then reads the ring and descriptor again for the new front
// o_busy drops on the result cycle, so the next command can transfer there
// after reset a clearing pass over POOL_DEPTH+1 entries rebuilds the free list with
// o_busy high; configuration writes are taken at any time
// the result is shown for one cycle only, the receiver cannot stall it
`default_nettype none

module descriptor_pool_fifo #(
    parameter int POOL_DEPTH = 64,
    parameter int RING_DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // command channel
    input  wire                                 i_start,
    output logic                                o_busy,
    input  dpf_pkg::t_item                      i_item,
    // result channel
    output logic                                o_result_valid,
    output dpf_pkg::t_result                    o_result,
    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [dpf_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire [dpf_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [dpf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    dpf_pkg::t_dp_ctl            w_ctl;
    dpf_pkg::t_dp_sts            w_sts;
    logic [dpf_pkg::CNT_W-1:0]   r_queue_limit;
    logic                        w_cfg_wr;
    logic                        w_sel_limit;

    // single register at byte address 0, paddr[2] selects the register
    assign pready      = 1'b1;
    assign w_sel_limit = (paddr[2] == dpf_pkg::REG_QUEUE_LIMIT);
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign prdata      = w_sel_limit ? dpf_pkg::CFG_DATA_W'(r_queue_limit) : '0;

    // queue limit, a value of zero makes every enqueue with a valid index report full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= dpf_pkg::QUEUE_LIMIT_RST;
        end else if (w_cfg_wr && w_sel_limit) begin
            r_queue_limit <= pwdata[dpf_pkg::CNT_W-1:0];
        end
    end

    // sequencer
    dpf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_sts          (w_sts),
        .o_ctl          (w_ctl),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid)
    );

    // memories, free-list head, ring pointers and result registers
    dpf_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_item        (i_item),
        .i_queue_limit (r_queue_limit),
        .o_sts         (w_sts),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire
